// ----- src/dual_8bit_compare_timer_core_macros.svh -----
// Assertion macros for the dual 8-bit compare timer core.
// Included by the top level; the macros expect clk and arst_n in scope.
`ifndef DUAL_8BIT_COMPARE_TIMER_CORE_MACROS_SVH
`define DUAL_8BIT_COMPARE_TIMER_CORE_MACROS_SVH

`define DTC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define DTC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/dtc_pkg.sv -----
// Shared types, codes and clock selection functions of the dual 8-bit compare timer.
// Used by dtc_count and dual_8bit_compare_timer_core; depends on nothing.
package dtc_pkg;

	localparam int CNT_W   = 8;
	localparam int PRESC_W = 13;

	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_READ  = 2'd1;
	localparam logic [1:0] FUNC_WRITE = 2'd2;

	localparam logic [2:0] REG_CONTROL = 3'd0;
	localparam logic [2:0] REG_STATUS  = 3'd1;
	localparam logic [2:0] REG_CMPA    = 3'd2;
	localparam logic [2:0] REG_CMPB    = 3'd3;
	localparam logic [2:0] REG_COUNTER = 3'd4;
	localparam logic [2:0] REG_CKSEL   = 3'd5;

	localparam logic [1:0] CSS_EXTERNAL = 2'd0;
	localparam logic [1:0] CSS_CASCADE  = 2'd3;
	localparam logic [2:0] CKS_CASCADE  = 3'd4;

	localparam logic [7:0] STATUS_RESET_CH1 = 8'h10;
	localparam logic [7:0] COMPARE_RESET    = 8'hff;

	typedef struct packed {
		logic               run;
		logic [PRESC_W-1:0] mask;
	} clk_sel_t;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic [7:0]       stat;
		logic             ovf;
		logic             cma;
	} count_res_t;

	function automatic logic [PRESC_W-1:0] cksel_mask(input logic [2:0] code);
		logic [PRESC_W-1:0] m;
		unique case (code)
			3'd0: m = PRESC_W'(0);
			3'd1: m = PRESC_W'(0);
			3'd2: m = PRESC_W'(1);
			3'd3: m = PRESC_W'(7);
			3'd4: m = PRESC_W'(31);
			3'd5: m = PRESC_W'(63);
			3'd6: m = PRESC_W'(1023);
			default: m = PRESC_W'(8191);
		endcase
		return m;
	endfunction

	function automatic logic [PRESC_W-1:0] ctrl_mask(input logic [1:0] code);
		logic [PRESC_W-1:0] m;
		unique case (code)
			2'd0: m = PRESC_W'(0);
			2'd1: m = PRESC_W'(7);
			2'd2: m = PRESC_W'(63);
			default: m = PRESC_W'(8191);
		endcase
		return m;
	endfunction

	function automatic logic chan_cascaded(input logic variant, input logic [7:0] ctrl,
			input logic [7:0] cksel);
		return variant ? (ctrl[2:0] == CKS_CASCADE) : (cksel[4:3] == CSS_CASCADE);
	endfunction

	function automatic clk_sel_t chan_clock(input logic variant, input logic [7:0] ctrl,
			input logic [7:0] cksel);
		clk_sel_t c;
		if (variant) begin
			c.run  = !ctrl[2] && (ctrl[1:0] != 2'd0);
			c.mask = ctrl_mask(ctrl[1:0]);
		end else begin
			c.run  = (cksel[4:3] != CSS_EXTERNAL) && (cksel[2:0] != 3'd0);
			c.mask = cksel_mask(cksel[2:0]);
		end
		return c;
	endfunction

endpackage

// ----- src/dtc_count.sv -----
// One count step of a timer channel: increment, compare A/B, clear and overflow.
// Purely combinational; depends on dtc_pkg.
module dtc_count (
	input  logic [dtc_pkg::CNT_W-1:0] cnt,
	input  logic [7:0]                stat,
	input  logic [7:0]                cmpa,
	input  logic [7:0]                cmpb,
	input  logic [1:0]                cclr,
	output dtc_pkg::count_res_t       res
);

	logic [dtc_pkg::CNT_W:0] next;
	logic                    hit_a;
	logic                    hit_b;

	always_comb begin
		next  = {1'b0, cnt} + {{dtc_pkg::CNT_W{1'b0}}, 1'b1};
		hit_a = (next == {1'b0, cmpa});
		hit_b = (next == {1'b0, cmpb});
		res.ovf  = next[dtc_pkg::CNT_W];
		res.cma  = hit_a;
		res.stat = stat | {hit_b, hit_a, next[dtc_pkg::CNT_W], 5'b0};
		if ((hit_a && cclr[0]) || (hit_b && cclr[1])) begin
			res.cnt = '0;
		end else begin
			res.cnt = next[dtc_pkg::CNT_W-1:0];
		end
	end

endmodule

// ----- src/dual_8bit_compare_timer_core.sv -----
// Top level of the dual 8-bit compare timer: input register, register file,
// tick logic and result register. Depends on dtc_pkg, dtc_count and the macro header.
//
// Usage. Each input word is a clock tick, a register read or a register write
// (func, reg_addr, word_access, write_data), taken when in_valid is high and
// in_stall is low. The word is registered, then executed against the register
// file once the output register is empty or not stalled, when its result word
// (read_data, bus_error and the three interrupt request pairs as they stand after the
// word) is loaded into the output register and out_valid rises. One word is accepted
// every cycle while in_stall is low; each word updates the register file as its
// result is loaded, so ticks and bus accesses run back to back. When the receiver
// raises out_stall the result is held, one further word waits in the input register,
// and in_stall rises only once both are full. cfg_we with cfg_wdata selects the clock
// selection variant; the user must write it only while the block is idle, which the
// block itself does not enforce. Reset clears the prescaler, counters and control
// registers, sets compares to all ones and channel 1 status to 0x10.
`include "dual_8bit_compare_timer_core_macros.svh"

module dual_8bit_compare_timer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [3:0]  reg_addr,
	input  logic        word_access,
	input  logic [15:0] write_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] read_data,
	output logic        bus_error,
	output logic [1:0]  match_a_irq,
	output logic [1:0]  match_b_irq,
	output logic [1:0]  overflow_irq
);

	logic        valid_s1;
	logic [1:0]  func_s1;
	logic [3:0]  addr_s1;
	logic        word_s1;
	logic [15:0] wdata_s1;
	logic        adv;
	logic        variant_q;

	logic [7:0]                     ctrl_q  [2];
	logic [7:0]                     stat_q  [2];
	logic [7:0]                     cmpa_q  [2];
	logic [7:0]                     cmpb_q  [2];
	logic [dtc_pkg::CNT_W-1:0]      cnt_q   [2];
	logic [7:0]                     cksel_q [2];
	logic [dtc_pkg::PRESC_W-1:0]    presc_q;

	logic [7:0]                     ctrl_d  [2];
	logic [7:0]                     stat_d  [2];
	logic [7:0]                     cmpa_d  [2];
	logic [7:0]                     cmpb_d  [2];
	logic [dtc_pkg::CNT_W-1:0]      cnt_d   [2];
	logic [7:0]                     cksel_d [2];
	logic [dtc_pkg::PRESC_W-1:0]    presc_d;

	dtc_pkg::count_res_t res [2];
	dtc_pkg::clk_sel_t   csel [2];
	logic [1:0]          casc;
	logic [1:0]          hit;
	logic [1:0]          en;
	logic [dtc_pkg::PRESC_W-1:0] p_next;

	logic        ch_s1;
	logic [2:0]  reg_s1;
	logic        err;
	logic [15:0] rd;
	logic        wr_en [2];
	logic [7:0]  wr_byte [2];

	assign adv      = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign ch_s1    = addr_s1[0];
	assign reg_s1   = addr_s1[3:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_s1  <= func;
			addr_s1  <= reg_addr;
			word_s1  <= word_access;
			wdata_s1 <= write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q <= 1'b0;
		end else if (cfg_we) begin
			variant_q <= cfg_wdata;
		end
	end

	for (genvar k = 0; k < 2; k++) begin : g_chan
		dtc_count u_count (
			.cnt  (cnt_q[k]),
			.stat (stat_q[k]),
			.cmpa (cmpa_q[k]),
			.cmpb (cmpb_q[k]),
			.cclr (ctrl_q[k][4:3]),
			.res  (res[k])
		);
		assign csel[k] = dtc_pkg::chan_clock(variant_q, ctrl_q[k], cksel_q[k]);
		assign casc[k] = dtc_pkg::chan_cascaded(variant_q, ctrl_q[k], cksel_q[k]);
		assign hit[k]  = csel[k].run && !casc[k] && ((p_next & csel[k].mask) == '0);
	end

	assign p_next = presc_q + dtc_pkg::PRESC_W'(1);
	assign en[0]  = hit[0] || (casc[0] && !casc[1] && hit[1] && res[1].ovf);
	assign en[1]  = hit[1] || (casc[1] && !casc[0] && hit[0] && res[0].cma);

	function automatic logic [7:0] reg_byte(input logic [2:0] r, input logic k,
			input logic [7:0] ctrl, input logic [7:0] stat, input logic [7:0] ca,
			input logic [7:0] cb, input logic [7:0] cn, input logic [7:0] cs);
		logic [7:0] v;
		unique case (r)
			dtc_pkg::REG_CONTROL: v = ctrl;
			dtc_pkg::REG_STATUS:  v = {3'b0, k | stat[4], stat[3:0]};
			dtc_pkg::REG_CMPA:    v = ca;
			dtc_pkg::REG_CMPB:    v = cb;
			dtc_pkg::REG_COUNTER: v = cn;
			default:              v = cs & 8'h9f;
		endcase
		return v;
	endfunction

	always_comb begin
		ctrl_d  = ctrl_q;
		stat_d  = stat_q;
		cmpa_d  = cmpa_q;
		cmpb_d  = cmpb_q;
		cnt_d   = cnt_q;
		cksel_d = cksel_q;
		presc_d = presc_q;
		err     = 1'b0;
		rd      = 16'h0000;
		for (int k = 0; k < 2; k++) begin
			wr_en[k]   = 1'b0;
			wr_byte[k] = (word_s1 && k == 0) ? wdata_s1[15:8] : wdata_s1[7:0];
		end
		unique case (func_s1)
			dtc_pkg::FUNC_TICK: begin
				presc_d = p_next;
				for (int k = 0; k < 2; k++) begin
					if (en[k]) begin
						cnt_d[k]  = res[k].cnt;
						stat_d[k] = res[k].stat;
					end
				end
			end
			dtc_pkg::FUNC_READ: begin
				err = (word_s1 && (ch_s1 || reg_s1 <= dtc_pkg::REG_STATUS)) ||
					(reg_s1 > dtc_pkg::REG_CKSEL);
				if (err) begin
					rd = 16'hffff;
				end else if (word_s1) begin
					rd = {reg_byte(reg_s1, 1'b0, ctrl_q[0], stat_q[0], cmpa_q[0], cmpb_q[0],
							cnt_q[0], cksel_q[0]),
						reg_byte(reg_s1, 1'b1, ctrl_q[1], stat_q[1], cmpa_q[1], cmpb_q[1],
							cnt_q[1], cksel_q[1])};
				end else begin
					rd = {8'h00, reg_byte(reg_s1, ch_s1, ctrl_q[ch_s1], stat_q[ch_s1],
						cmpa_q[ch_s1], cmpb_q[ch_s1], cnt_q[ch_s1], cksel_q[ch_s1])};
				end
			end
			dtc_pkg::FUNC_WRITE: begin
				err = (word_s1 && ch_s1) || (reg_s1 > dtc_pkg::REG_CKSEL);
				if (err) begin
					rd = 16'hffff;
				end
				for (int k = 0; k < 2; k++) begin
					wr_en[k] = !err && (word_s1 || (ch_s1 == k[0]));
					if (wr_en[k]) begin
						unique case (reg_s1)
							dtc_pkg::REG_CONTROL: ctrl_d[k]  = wr_byte[k];
							dtc_pkg::REG_STATUS:  stat_d[k]  = wr_byte[k];
							dtc_pkg::REG_CMPA:    cmpa_d[k]  = wr_byte[k];
							dtc_pkg::REG_CMPB:    cmpb_d[k]  = wr_byte[k];
							dtc_pkg::REG_COUNTER: cnt_d[k]   = wr_byte[k];
							default:              cksel_d[k] = wr_byte[k];
						endcase
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			presc_q <= '0;
			for (int k = 0; k < 2; k++) begin
				ctrl_q[k]  <= 8'h00;
				cmpa_q[k]  <= dtc_pkg::COMPARE_RESET;
				cmpb_q[k]  <= dtc_pkg::COMPARE_RESET;
				cnt_q[k]   <= '0;
				cksel_q[k] <= 8'h00;
			end
			stat_q[0] <= 8'h00;
			stat_q[1] <= dtc_pkg::STATUS_RESET_CH1;
		end else if (adv) begin
			presc_q <= presc_d;
			ctrl_q  <= ctrl_d;
			stat_q  <= stat_d;
			cmpa_q  <= cmpa_d;
			cmpb_q  <= cmpb_d;
			cnt_q   <= cnt_d;
			cksel_q <= cksel_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			read_data <= rd;
			bus_error <= err;
			for (int k = 0; k < 2; k++) begin
				match_a_irq[k]  <= ctrl_d[k][6] & stat_d[k][6];
				match_b_irq[k]  <= ctrl_d[k][7] & stat_d[k][7];
				overflow_irq[k] <= ctrl_d[k][5] & stat_d[k][5];
			end
		end
	end

	`DTC_ASSERT_IMP(a_err_all_ones, out_valid && bus_error, read_data == 16'hffff,
		"Bus error result does not read as all ones.")
	`DTC_ASSERT_IMP(a_stall_needs_word, in_stall, valid_s1 && out_valid && out_stall,
		"Input stalled without a held word on both sides.")
	`DTC_ASSERT_NXT(a_tick_prescaler, adv && func_s1 == dtc_pkg::FUNC_TICK,
		presc_q == dtc_pkg::PRESC_W'($past(presc_q) + dtc_pkg::PRESC_W'(1)),
		"Prescaler did not advance on a tick.")
	`DTC_ASSERT_NXT(a_access_keeps_prescaler, adv && func_s1 != dtc_pkg::FUNC_TICK,
		$stable(presc_q), "Prescaler moved on a register access.")

endmodule

// ----- bench/dual_8bit_compare_timer_core_test.sv -----
// Self-checking bench for the dual 8-bit compare timer core: ticks, register reads and writes,
// predicted word by word and compared with every result word under random gaps and stalls.
// Depends on dtc_pkg and dual_8bit_compare_timer_core.
module dual_8bit_compare_timer_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int CTRL_CLR_A = 3;
	localparam int CTRL_CLR_B = 4;
	localparam int CTRL_OVIE = 5;
	localparam int CTRL_CMIEA = 6;
	localparam int CTRL_CMIEB = 7;
	localparam int STAT_ADTE = 4;
	localparam int STAT_OVF = 5;
	localparam int STAT_CMFA = 6;
	localparam int STAT_CMFB = 7;
	localparam logic [7:0] STAT_READ_MASK = 8'h0f;
	localparam logic [7:0] CKSEL_READ_MASK = 8'h9f;
	localparam int EV_OVF = 0;
	localparam int EV_MATCH_A = 1;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_PRINTS = 40;
	localparam int RANDOM_PER_PHASE = 335;

	typedef struct packed {
		logic [1:0]  func;
		logic [3:0]  addr;
		logic        word;
		logic [15:0] data;
	} bus_word_t;

	typedef struct packed {
		logic      is_cfg;
		logic      cfg_val;
		bus_word_t w;
	} stim_item_t;

	typedef struct packed {
		logic [15:0] rd;
		logic        err;
		logic [1:0]  ia;
		logic [1:0]  ib;
		logic [1:0]  io;
	} timer_result_t;

	typedef struct packed {
		logic [7:0] ctrl;
		logic [7:0] stat;
		logic [7:0] cmpa;
		logic [7:0] cmpb;
		logic [7:0] cnt;
		logic [7:0] cksel;
	} chan_regs_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  func = 2'd0;
	logic [3:0]  reg_addr = 4'd0;
	logic        word_access = 1'b0;
	logic [15:0] write_data = 16'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] read_data;
	logic        bus_error;
	logic [1:0]  match_a_irq;
	logic [1:0]  match_b_irq;
	logic [1:0]  overflow_irq;

	dual_8bit_compare_timer_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.reg_addr     (reg_addr),
		.word_access  (word_access),
		.write_data   (write_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.read_data    (read_data),
		.bus_error    (bus_error),
		.match_a_irq  (match_a_irq),
		.match_b_irq  (match_b_irq),
		.overflow_irq (overflow_irq)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	chan_regs_t                  tmr [2];
	logic [dtc_pkg::PRESC_W-1:0] presc_model;
	logic                        variant_model;

	stim_item_t    stim_q [$];
	timer_result_t pending_results_q [$];

	logic word_taken = 1'b0;
	logic all_done = 1'b0;
	int   gap_left = 0;
	int   stall_left = 0;
	int   calm_left = 0;
	int   settle_left = SETTLE_CYCLES;
	int   idle_cycles = 0;
	int   mismatch_count = 0;
	int   results_checked = 0;
	int   tick_words = 0;
	int   read_words = 0;
	int   write_words = 0;
	int   error_results = 0;
	int   irq_results = 0;
	int   variant_writes = 0;

	function automatic logic is_chained(input int c);
		if (variant_model)
			return tmr[c].ctrl[2:0] == dtc_pkg::CKS_CASCADE;
		return tmr[c].cksel[4:3] == dtc_pkg::CSS_CASCADE;
	endfunction

	function automatic int tick_divisor(input int c);
		if (!variant_model) begin
			if (tmr[c].cksel[4:3] == dtc_pkg::CSS_EXTERNAL)
				return 0;
			case (tmr[c].cksel[2:0])
				3'd0: return 0;
				3'd1: return 1;
				3'd2: return 2;
				3'd3: return 8;
				3'd4: return 32;
				3'd5: return 64;
				3'd6: return 1024;
				default: return 8192;
			endcase
		end
		if (tmr[c].ctrl[2])
			return 0;
		case (tmr[c].ctrl[1:0])
			2'd0: return 0;
			2'd1: return 8;
			2'd2: return 64;
			default: return 8192;
		endcase
	endfunction

	function automatic logic [1:0] count_once(input int c);
		logic [8:0] nxt;
		logic [1:0] ev;
		nxt = {1'b0, tmr[c].cnt} + 9'd1;
		ev = 2'b00;
		tmr[c].cnt = nxt[7:0];
		if (nxt == {1'b0, tmr[c].cmpa}) begin
			tmr[c].stat[STAT_CMFA] = 1'b1;
			ev[EV_MATCH_A] = 1'b1;
			if (tmr[c].ctrl[CTRL_CLR_A])
				tmr[c].cnt = 8'd0;
		end
		if (nxt == {1'b0, tmr[c].cmpb}) begin
			tmr[c].stat[STAT_CMFB] = 1'b1;
			if (tmr[c].ctrl[CTRL_CLR_B])
				tmr[c].cnt = 8'd0;
		end
		if (nxt[8]) begin
			tmr[c].stat[STAT_OVF] = 1'b1;
			ev[EV_OVF] = 1'b1;
		end
		return ev;
	endfunction

	function automatic void advance_tick();
		logic       chained [2];
		logic [1:0] ev [2];
		int         d;
		chained[0] = is_chained(0);
		chained[1] = is_chained(1);
		presc_model = presc_model + 1'b1;
		for (int c = 0; c < 2; c++) begin
			ev[c] = 2'b00;
			d = tick_divisor(c);
			if (!chained[c] && d != 0 && (int'(presc_model) & (d - 1)) == 0)
				ev[c] = count_once(c);
		end
		if (chained[0] && !chained[1] && ev[1][EV_OVF])
			ev[0] = count_once(0);
		if (chained[1] && !chained[0] && ev[0][EV_MATCH_A])
			void'(count_once(1));
	endfunction

	function automatic logic [7:0] view_reg(input logic [2:0] r, input int c);
		case (r)
			dtc_pkg::REG_CONTROL: return tmr[c].ctrl;
			dtc_pkg::REG_STATUS: return (tmr[c].stat & STAT_READ_MASK)
				| ((c != 0) ? dtc_pkg::STATUS_RESET_CH1
					: (tmr[c].stat & (8'h01 << STAT_ADTE)));
			dtc_pkg::REG_CMPA: return tmr[c].cmpa;
			dtc_pkg::REG_CMPB: return tmr[c].cmpb;
			dtc_pkg::REG_COUNTER: return tmr[c].cnt;
			default: return tmr[c].cksel & CKSEL_READ_MASK;
		endcase
	endfunction

	function automatic void load_reg(input logic [2:0] r, input int c, input logic [7:0] v);
		case (r)
			dtc_pkg::REG_CONTROL: tmr[c].ctrl = v;
			dtc_pkg::REG_STATUS: tmr[c].stat = v;
			dtc_pkg::REG_CMPA: tmr[c].cmpa = v;
			dtc_pkg::REG_CMPB: tmr[c].cmpb = v;
			dtc_pkg::REG_COUNTER: tmr[c].cnt = v;
			default: tmr[c].cksel = v;
		endcase
	endfunction

	function automatic timer_result_t predict_timer_word(input bus_word_t w);
		timer_result_t res;
		logic [2:0]    r;
		int            c;
		res = '0;
		r = w.addr[3:1];
		c = int'(w.addr[0]);
		case (w.func)
			dtc_pkg::FUNC_TICK: advance_tick();
			dtc_pkg::FUNC_READ: begin
				if ((w.word && (c != 0 || r <= dtc_pkg::REG_STATUS))
						|| r > dtc_pkg::REG_CKSEL) begin
					res.err = 1'b1;
					res.rd = 16'hffff;
				end else if (w.word) begin
					res.rd = {view_reg(r, 0), view_reg(r, 1)};
				end else begin
					res.rd = {8'd0, view_reg(r, c)};
				end
			end
			dtc_pkg::FUNC_WRITE: begin
				if ((w.word && c != 0) || r > dtc_pkg::REG_CKSEL) begin
					res.err = 1'b1;
					res.rd = 16'hffff;
				end else if (w.word) begin
					load_reg(r, 0, w.data[15:8]);
					load_reg(r, 1, w.data[7:0]);
				end else begin
					load_reg(r, c, w.data[7:0]);
				end
			end
			default: ;
		endcase
		for (int k = 0; k < 2; k++) begin
			res.ia[k] = tmr[k].ctrl[CTRL_CMIEA] & tmr[k].stat[STAT_CMFA];
			res.ib[k] = tmr[k].ctrl[CTRL_CMIEB] & tmr[k].stat[STAT_CMFB];
			res.io[k] = tmr[k].ctrl[CTRL_OVIE] & tmr[k].stat[STAT_OVF];
		end
		return res;
	endfunction

	function automatic logic [7:0] gen_reg_byte(input logic [2:0] r);
		logic [7:0] v;
		v = 8'($urandom);
		case (r)
			dtc_pkg::REG_CONTROL:
				if ($urandom_range(0, 1) == 1)
					v[2:0] = 3'($urandom_range(1, 4));
			dtc_pkg::REG_STATUS:
				if ($urandom_range(0, 2) == 0)
					v = 8'd0;
			dtc_pkg::REG_CMPA, dtc_pkg::REG_CMPB:
				if ($urandom_range(0, 2) != 0)
					v = 8'($urandom_range(0, 12));
			dtc_pkg::REG_COUNTER:
				case ($urandom_range(0, 2))
					0: v = 8'($urandom_range(0, 6));
					1: v = 8'hf8 | 8'($urandom_range(0, 7));
					default: ;
				endcase
			dtc_pkg::REG_CKSEL:
				if ($urandom_range(0, 3) != 0) begin
					v[4:3] = 2'($urandom_range(1, 3));
					v[2:0] = 3'($urandom_range(1, 4));
				end
			default: ;
		endcase
		return v;
	endfunction

	// Mostly ticks and accesses to implemented registers; a few words are fully random.
	function automatic bus_word_t random_bus_word();
		bus_word_t  w;
		logic [2:0] r;
		logic       c;
		int         k;
		k = $urandom_range(0, 99);
		w.func = dtc_pkg::FUNC_TICK;
		w.addr = 4'($urandom);
		w.word = 1'b0;
		w.data = 16'($urandom);
		if (k < 5) begin
			w.func = 2'($urandom);
			w.word = 1'($urandom);
			return w;
		end
		if (k < 58)
			return w;
		r = ($urandom_range(0, 29) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
		w.word = ($urandom_range(0, 5) == 0);
		c = w.word ? ($urandom_range(0, 7) == 0) : 1'($urandom);
		w.addr = {r, c};
		if (k < 75) begin
			w.func = dtc_pkg::FUNC_READ;
		end else begin
			w.func = dtc_pkg::FUNC_WRITE;
			w.data = {w.word ? gen_reg_byte(r) : 8'($urandom), gen_reg_byte(r)};
		end
		return w;
	endfunction

	function automatic int pick_gap();
		int k;
		if (calm_left > 0)
			return 0;
		k = $urandom_range(0, 99);
		if (k < 60)
			return 0;
		if (k < 88)
			return $urandom_range(1, 3);
		if (k < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic queue_word(input logic [1:0] f, input logic [3:0] a, input logic wd,
			input logic [15:0] d);
		stim_q.push_back('{is_cfg: 1'b0, cfg_val: 1'b0, w: '{func: f, addr: a, word: wd, data: d}});
	endtask

	task automatic queue_variant(input logic v);
		stim_q.push_back('{is_cfg: 1'b1, cfg_val: v, w: '0});
	endtask

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTS)
			$display("MISMATCH %s at result %0d: got %h, expected %h", what, results_checked,
				got, want);
	endtask

	always @(negedge clk) begin
		logic       nv;
		logic       cwe;
		logic       ns;
		int         k;
		stim_item_t head;
		nv = in_valid;
		cwe = 1'b0;
		ns = 1'b0;
		if (arst_n) begin
			if (calm_left > 0)
				calm_left--;
			else if ($urandom_range(0, 149) == 0)
				calm_left = $urandom_range(20, 80);
			if (word_taken) begin
				nv = 1'b0;
				word_taken = 1'b0;
			end
			if (!nv) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (stim_q.size() != 0) begin
					head = stim_q[0];
					if (!head.is_cfg) begin
						head = stim_q.pop_front();
						func <= head.w.func;
						reg_addr <= head.w.addr;
						word_access <= head.w.word;
						write_data <= head.w.data;
						nv = 1'b1;
						gap_left = pick_gap();
					end else if (pending_results_q.size() != 0 || out_valid) begin
						settle_left = SETTLE_CYCLES;
					end else if (settle_left > 0) begin
						settle_left--;
					end else begin
						head = stim_q.pop_front();
						cwe = 1'b1;
						cfg_wdata <= head.cfg_val;
						settle_left = SETTLE_CYCLES;
					end
				end
			end
			if (calm_left > 0) begin
				stall_left = 0;
			end else if (stall_left > 0) begin
				ns = 1'b1;
				stall_left--;
			end else begin
				k = $urandom_range(0, 99);
				if (k >= 75) begin
					ns = 1'b1;
					stall_left = (k >= 98) ? $urandom_range(15, 50) : $urandom_range(0, 3);
				end
			end
		end
		in_valid <= nv;
		cfg_we <= cwe;
		out_stall <= ns;
	end

	always @(posedge clk) begin
		timer_result_t want;
		logic          progress;
		progress = 1'b0;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				pending_results_q.push_back(predict_timer_word({func, reg_addr, word_access,
					write_data}));
				word_taken = 1'b1;
				progress = 1'b1;
				case (func)
					dtc_pkg::FUNC_TICK: tick_words++;
					dtc_pkg::FUNC_READ: read_words++;
					dtc_pkg::FUNC_WRITE: write_words++;
					default: ;
				endcase
			end
			if (cfg_we) begin
				variant_model = cfg_wdata;
				variant_writes++;
				progress = 1'b1;
			end
			if (out_valid && !out_stall) begin
				progress = 1'b1;
				if (pending_results_q.size() == 0) begin
					report_mismatch("result word with none expected", read_data, 16'd0);
				end else begin
					want = pending_results_q.pop_front();
					if (read_data !== want.rd)
						report_mismatch("read_data", read_data, want.rd);
					if (bus_error !== want.err)
						report_mismatch("bus_error", 16'(bus_error), 16'(want.err));
					if (match_a_irq !== want.ia)
						report_mismatch("match_a_irq", 16'(match_a_irq), 16'(want.ia));
					if (match_b_irq !== want.ib)
						report_mismatch("match_b_irq", 16'(match_b_irq), 16'(want.ib));
					if (overflow_irq !== want.io)
						report_mismatch("overflow_irq", 16'(overflow_irq), 16'(want.io));
					if (want.err)
						error_results++;
					if ((want.ia | want.ib | want.io) != 2'b00)
						irq_results++;
					results_checked++;
				end
			end
			all_done = stim_q.size() == 0 && pending_results_q.size() == 0 && !in_valid;
			if (progress || all_done)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog expired: no handshake for %0d cycles, %0d results outstanding",
					idle_cycles, pending_results_q.size());
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		for (int c = 0; c < 2; c++) begin
			tmr[c].ctrl = 8'd0;
			tmr[c].stat = 8'd0;
			tmr[c].cmpa = dtc_pkg::COMPARE_RESET;
			tmr[c].cmpb = dtc_pkg::COMPARE_RESET;
			tmr[c].cnt = 8'd0;
			tmr[c].cksel = 8'd0;
		end
		tmr[1].stat = dtc_pkg::STATUS_RESET_CH1;
		presc_model = '0;
		variant_model = 1'b0;

		// Reset values, then the error cases: word access to control or status, odd word
		// addresses, addresses twelve and up, and the unused function code.
		queue_word(dtc_pkg::FUNC_READ, {dtc_pkg::REG_STATUS, 1'b1}, 1'b0, 16'h0000);
		queue_word(dtc_pkg::FUNC_READ, {dtc_pkg::REG_CONTROL, 1'b0}, 1'b1, 16'h0000);
		queue_word(dtc_pkg::FUNC_READ, {dtc_pkg::REG_CMPA, 1'b1}, 1'b1, 16'hffff);
		queue_word(dtc_pkg::FUNC_WRITE, 4'd14, 1'b0, 16'hffff);
		queue_word(dtc_pkg::FUNC_READ, 4'd15, 1'b1, 16'h0000);
		queue_word(FUNC_UNUSED, {dtc_pkg::REG_CMPA, 1'b0}, 1'b1, 16'hffff);
		// Both channels counting every tick, channel 0 clearing on compare A.
		queue_word(dtc_pkg::FUNC_WRITE, {dtc_pkg::REG_CMPA, 1'b0}, 1'b1, 16'h0201);
		queue_word(dtc_pkg::FUNC_WRITE, {dtc_pkg::REG_CMPB, 1'b0}, 1'b1, 16'hffff);
		queue_word(dtc_pkg::FUNC_WRITE, {dtc_pkg::REG_CKSEL, 1'b0}, 1'b1, 16'h0909);
		queue_word(dtc_pkg::FUNC_WRITE, {dtc_pkg::REG_CONTROL, 1'b0}, 1'b0, 16'h00e8);
		repeat (4) queue_word(dtc_pkg::FUNC_TICK, 4'd0, 1'b0, 16'h0000);
		// Status writes store the flags; reads show only the low bits.
		queue_word(dtc_pkg::FUNC_WRITE, {dtc_pkg::REG_STATUS, 1'b0}, 1'b0, 16'h00ff);
		queue_word(dtc_pkg::FUNC_READ, {dtc_pkg::REG_STATUS, 1'b0}, 1'b0, 16'h0000);
		// Channel 1 cascaded on channel 0 compare A; clock select reads mask bits 6 and 5.
		queue_word(dtc_pkg::FUNC_WRITE, {dtc_pkg::REG_CKSEL, 1'b1}, 1'b0, 16'h00ff);
		queue_word(dtc_pkg::FUNC_READ, {dtc_pkg::REG_CKSEL, 1'b0}, 1'b1, 16'h0000);
		repeat (3) queue_word(dtc_pkg::FUNC_TICK, 4'd0, 1'b0, 16'h0000);
		// Wrap from 0xff, which must not match a compare value of zero.
		queue_word(dtc_pkg::FUNC_WRITE, {dtc_pkg::REG_COUNTER, 1'b0}, 1'b1, 16'hfeff);
		queue_word(dtc_pkg::FUNC_WRITE, {dtc_pkg::REG_CMPA, 1'b1}, 1'b0, 16'h0000);
		repeat (2) queue_word(dtc_pkg::FUNC_TICK, 4'd0, 1'b0, 16'h0000);
		queue_word(dtc_pkg::FUNC_READ, {dtc_pkg::REG_COUNTER, 1'b0}, 1'b1, 16'h0000);
		queue_word(dtc_pkg::FUNC_WRITE, {dtc_pkg::REG_CONTROL, 1'b1}, 1'b0, 16'h0018);
		queue_word(dtc_pkg::FUNC_WRITE, {dtc_pkg::REG_COUNTER, 1'b1}, 1'b0, 16'h0000);

		for (int phase = 0; phase < 4; phase++) begin
			queue_variant(phase % 2 == 0);
			repeat (RANDOM_PER_PHASE) begin
				stim_q.push_back('{is_cfg: 1'b0, cfg_val: 1'b0, w: random_bus_word()});
			end
		end

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		do
			@(negedge clk);
		while (!all_done);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (pending_results_q.size() != 0)
			report_mismatch("result words never produced", 16'(pending_results_q.size()), 16'd0);

		$display("Checked %0d result words: %0d ticks, %0d reads, %0d writes, %0d bus errors.",
			results_checked, tick_words, read_words, write_words, error_results);
		$display("%0d results carried an interrupt request; clock variant written %0d times.",
			irq_results, variant_writes);
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
